// ===== rtl/qfe_pkg.sv =====
// Shared types, codes and constants of the Quinn frequency estimator.
package qfe_pkg;

  // Controller states
  typedef enum logic [3:0] {
    ST_IDLE, ST_CHECK, ST_MULA, ST_ZCHK, ST_DIV1S, ST_DIV1W,
    ST_DIV2S, ST_DIV2W, ST_MULB, ST_DONE
  } qfe_state_t;

  // Operand pair for the shared multiplier
  typedef enum logic [3:0] {
    MOP_KFS, MOP_PR2, MOP_PI2, MOP_PRV_R, MOP_PRV_I,
    MOP_NXT_R, MOP_NXT_I, MOP_POS, MOP_CONF
  } qfe_mop_t;

  // Where the registered product goes
  typedef enum logic [3:0] {
    CON_NONE, CON_COARSE, CON_DEN, CON_DEN_ADD, CON_M1_PRV, CON_B1_NUM,
    CON_M1_NXT, CON_B2_NUM, CON_FINE, CON_CONF
  } qfe_con_t;

  // Result status codes
  typedef enum logic [1:0] {
    STAT_OK, STAT_DISABLED, STAT_BAD_INDEX, STAT_ZERO_PEAK
  } qfe_status_t;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_ENABLE    = 2'd0;
  localparam logic [1:0] REG_SAMPLE_HZ = 2'd1;
  localparam logic [1:0] REG_THRESHOLD = 2'd2;

  localparam logic [2:0] MULA_LAST = 3'd7;
  localparam logic [2:0] MULB_LAST = 3'd2;

  localparam logic signed [23:0] Q824_MAX = 24'sh7FFFFF;
  localparam logic signed [23:0] Q824_MIN = 24'sh800000;
  localparam logic [16:0] Q16_ONE = 17'd65536;
  // floor(x/100) = (x * ceil(2^30/100)) >> 30 for x below 14e6
  localparam logic [31:0] RECIP100    = 32'd10737419;
  localparam int          RECIP_SHIFT = 30;
  localparam logic [33:0] CONF_K1     = 34'd6422528;
  localparam logic [33:0] CONF_K2     = 34'd1572864;

  // Controller to datapath commands
  typedef struct packed {
    logic     load;
    logic     zchk;
    qfe_mop_t mop;
    qfe_con_t con;
    logic     div_start;
    logic     div_phase;
    logic     div_latch;
    logic     commit;
  } qfe_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic reject;
    logic den_zero;
    logic div_busy;
    logic out_free;
  } qfe_sts_t;

  // First multiply phase: product issued at each step
  function automatic qfe_mop_t mula_op(input logic [2:0] s);
    qfe_mop_t r;
    case (s)
      3'd0:    r = MOP_KFS;
      3'd1:    r = MOP_PR2;
      3'd2:    r = MOP_PI2;
      3'd3:    r = MOP_PRV_R;
      3'd4:    r = MOP_PRV_I;
      3'd5:    r = MOP_NXT_R;
      3'd6:    r = MOP_NXT_I;
      default: r = MOP_KFS;
    endcase
    return r;
  endfunction

  // First multiply phase: product consumed at each step (issued one step earlier)
  function automatic qfe_con_t mula_con(input logic [2:0] s);
    qfe_con_t r;
    case (s)
      3'd1:    r = CON_COARSE;
      3'd2:    r = CON_DEN;
      3'd3:    r = CON_DEN_ADD;
      3'd4:    r = CON_M1_PRV;
      3'd5:    r = CON_B1_NUM;
      3'd6:    r = CON_M1_NXT;
      3'd7:    r = CON_B2_NUM;
      default: r = CON_NONE;
    endcase
    return r;
  endfunction

  function automatic qfe_mop_t mulb_op(input logic [2:0] s);
    return (s == 3'd0) ? MOP_POS : MOP_CONF;
  endfunction

  function automatic qfe_con_t mulb_con(input logic [2:0] s);
    qfe_con_t r;
    case (s)
      3'd1:    r = CON_FINE;
      3'd2:    r = CON_CONF;
      default: r = CON_NONE;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/qfe_div.sv =====
// Restoring divider: signed Q8.16 quotient of two magnitudes, truncated and saturated.
module qfe_div import qfe_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               neg,
  input  logic [63:0]        num,
  input  logic [63:0]        den,
  output logic               busy,
  output logic signed [23:0] quo
);

  localparam logic [4:0] QBITS = 5'd23;

  logic [71:0] rr_r;
  logic [71:0] rr_sub;
  logic [69:0] dv_r;
  logic [22:0] q_r;
  logic [4:0]  cnt_r;
  logic        busy_r;
  logic        neg_r;
  logic        sat_r;
  logic        zero_r;
  logic        ge;

  assign ge     = rr_r >= {2'b00, dv_r};
  assign rr_sub = ge ? (rr_r - {2'b00, dv_r}) : rr_r;

  // Step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= QBITS;
    end else if (busy_r) begin
      cnt_r <= cnt_r - 5'd1;
      if (cnt_r == 5'd1) busy_r <= 1'b0;
    end
  end

  // One quotient bit per cycle; divisor starts at den*64
  always_ff @(posedge clk) begin
    if (start) begin
      rr_r   <= {8'h00, num};
      dv_r   <= {den, 6'b000000};
      q_r    <= '0;
      neg_r  <= neg;
      zero_r <= (den == 64'd0);
      sat_r  <= ({8'h00, num} >= {1'b0, den, 7'b0000000});
    end else if (busy_r) begin
      rr_r <= {rr_sub[70:0], 1'b0};
      q_r  <= {q_r[21:0], ge};
    end
  end

  assign busy = busy_r;

  always_comb begin
    if (zero_r)     quo = '0;
    else if (sat_r) quo = neg_r ? Q824_MIN : Q824_MAX;
    else if (neg_r) quo = -$signed({1'b0, q_r});
    else            quo = $signed({1'b0, q_r});
  end

endmodule

// ===== rtl/qfe_datapath.sv =====
// Datapath: operand registers, shared multiplier, two dividers and held result.
module qfe_datapath import qfe_pkg::*; #(
  parameter int FFT_POINTS = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  qfe_cmd_t           cmd,
  output qfe_sts_t           sts,
  input  logic               enable,
  input  logic [23:0]        sample_rate_hz,
  input  logic [16:0]        confidence_threshold,
  input  logic [9:0]         in_bin_index,
  input  logic signed [31:0] in_re_prev,
  input  logic signed [31:0] in_im_prev,
  input  logic signed [31:0] in_re_peak,
  input  logic signed [31:0] in_im_peak,
  input  logic signed [31:0] in_re_next,
  input  logic signed [31:0] in_im_next,
  input  logic               out_stall,
  output logic               out_valid,
  output logic [1:0]         out_status,
  output logic [9:0]         out_bin_index,
  output logic [30:0]        out_coarse_freq,
  output logic signed [23:0] out_fine_offset,
  output logic signed [47:0] out_fine_frequency,
  output logic [16:0]        out_confidence,
  output logic               out_valid_res
);

  // FFT_POINTS is a power of two
  localparam int FFT_LOG2 = $clog2(FFT_POINTS);

  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    return v[31] ? 32'(-v) : 32'(v);
  endfunction

  // Captured transaction
  logic [9:0]  k_r;
  logic [31:0] mrp_r, mip_r, mrk_r, mik_r, mrn_r, min_r;
  logic        srp_r, sip_r, srk_r, sik_r, srn_r, sin_r;
  qfe_status_t stat_r;

  // Working registers
  logic [63:0]        prod_r, den_r, m1_r, num1_r, num2_r;
  logic               n1_r, neg1_r, neg2_r;
  logic [30:0]        coarse_r;
  logic signed [23:0] b1_r, b2_r, d_r;
  logic signed [47:0] fine_r;
  logic [16:0]        conf_r;

  // Held result and output handshake
  logic               out_valid_r;
  qfe_status_t        out_stat_r;
  logic [9:0]         hpk_r;
  logic [30:0]        hcoarse_r;
  logic signed [23:0] hoff_r;
  logic signed [47:0] hfreq_r;
  logic [16:0]        hconf_r;
  logic               hvalid_r;

  logic [31:0] mul_a, mul_b;
  logic        bad_k;
  logic        n2;
  logic [63:0] comb_m;
  logic        comb_neg;
  logic signed [27:0] pos;
  logic [26:0] pos_mag;
  logic [23:0] a_mag;
  logic [33:0] a34;
  logic [33:0] x_full;
  logic        c100, c10, c2;
  logic [71:0] csh;
  logic [63:0] fsh;
  logic [63:0] psh;
  logic [47:0] fm;
  logic signed [24:0] dn1, dn2;
  logic [23:0] b1_mag, b2_mag;
  logic [24:0] dn1_mag, dn2_mag;
  logic [63:0] da_num, da_den, db_num, db_den;
  logic        da_neg, db_neg;
  logic        busy_a, busy_b;
  logic signed [23:0] quo_a, quo_b;

  assign bad_k = (in_bin_index == 10'd0) ||
                 (32'(in_bin_index) >= 32'(FFT_POINTS / 2 - 1));

  // Capture transaction and early status
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      k_r   <= in_bin_index;
      mrp_r <= mag32(in_re_prev);  srp_r <= in_re_prev[31];
      mip_r <= mag32(in_im_prev);  sip_r <= in_im_prev[31];
      mrk_r <= mag32(in_re_peak);  srk_r <= in_re_peak[31];
      mik_r <= mag32(in_im_peak);  sik_r <= in_im_peak[31];
      mrn_r <= mag32(in_re_next);  srn_r <= in_re_next[31];
      min_r <= mag32(in_im_next);  sin_r <= in_im_next[31];
      if (!enable)    stat_r <= STAT_DISABLED;
      else if (bad_k) stat_r <= STAT_BAD_INDEX;
      else            stat_r <= STAT_OK;
    end else if (cmd.zchk && den_r == 64'd0) begin
      stat_r <= STAT_ZERO_PEAK;
    end
  end

  // Position k*65536 + delta and its magnitude
  assign pos     = $signed({2'b00, k_r, 16'h0000}) + 28'(d_r);
  assign pos_mag = pos[27] ? 27'(-pos) : pos[26:0];

  // Confidence segments on |delta|
  assign a_mag  = d_r[23] ? 24'(-d_r) : 24'(d_r);
  assign a34    = 34'(a_mag);
  assign c100   = (a34 * 34'd100) <= 34'(Q16_ONE);
  assign c10    = (a34 * 34'd10) <= 34'(Q16_ONE);
  assign c2     = (a34 * 34'd2) <= 34'(Q16_ONE);
  assign x_full = c10 ? (CONF_K1 - a34 * 34'd800) : (CONF_K2 - a34 * 34'd40);

  // Shared multiplier operand select
  always_comb begin
    case (cmd.mop)
      MOP_KFS:   begin mul_a = 32'(k_r);      mul_b = 32'(sample_rate_hz); end
      MOP_PR2:   begin mul_a = mrk_r;         mul_b = mrk_r;               end
      MOP_PI2:   begin mul_a = mik_r;         mul_b = mik_r;               end
      MOP_PRV_R: begin mul_a = mrp_r;         mul_b = mrk_r;               end
      MOP_PRV_I: begin mul_a = mip_r;         mul_b = mik_r;               end
      MOP_NXT_R: begin mul_a = mrn_r;         mul_b = mrk_r;               end
      MOP_NXT_I: begin mul_a = min_r;         mul_b = mik_r;               end
      MOP_POS:   begin mul_a = 32'(pos_mag);  mul_b = 32'(sample_rate_hz); end
      MOP_CONF:  begin mul_a = 32'(x_full[22:0]); mul_b = RECIP100;        end
      default:   begin mul_a = '0;            mul_b = '0;                  end
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= 64'(mul_a) * 64'(mul_b);
  end

  // Signed sum of the two cross products as sign and magnitude
  always_comb begin
    if (cmd.con == CON_B1_NUM) n2 = (sip_r ^ sik_r) && (prod_r != 64'd0);
    else                       n2 = (sin_r ^ sik_r) && (prod_r != 64'd0);
    if (n1_r == n2) begin
      comb_m = m1_r + prod_r;   comb_neg = n1_r;
    end else if (m1_r >= prod_r) begin
      comb_m = m1_r - prod_r;   comb_neg = n1_r;
    end else begin
      comb_m = prod_r - m1_r;   comb_neg = n2;
    end
  end

  assign csh = {prod_r, 8'h00} >> FFT_LOG2;
  assign fsh = prod_r >> (8 + FFT_LOG2);
  assign fm  = fsh[47:0];
  assign psh = prod_r >> RECIP_SHIFT;

  // Product consumers
  always_ff @(posedge clk) begin
    case (cmd.con)
      CON_COARSE:  coarse_r <= csh[30:0];
      CON_DEN:     den_r <= prod_r;
      CON_DEN_ADD: den_r <= den_r + prod_r;
      CON_M1_PRV: begin
        m1_r <= prod_r;
        n1_r <= (srp_r ^ srk_r) && (prod_r != 64'd0);
      end
      CON_M1_NXT: begin
        m1_r <= prod_r;
        n1_r <= (srn_r ^ srk_r) && (prod_r != 64'd0);
      end
      CON_B1_NUM: begin num1_r <= comb_m; neg1_r <= comb_neg; end
      CON_B2_NUM: begin num2_r <= comb_m; neg2_r <= comb_neg; end
      CON_FINE:    fine_r <= pos[27] ? -$signed(fm) : $signed(fm);
      CON_CONF: begin
        if (c100)     conf_r <= Q16_ONE;
        else if (!c2) conf_r <= '0;
        else          conf_r <= psh[16:0];
      end
      default: ;
    endcase
  end

  // Divider operands: betas first, then deltas
  assign dn1     = 25'sd65536 - 25'(b1_r);
  assign dn2     = 25'(b2_r) - 25'sd65536;
  assign b1_mag  = b1_r[23] ? 24'(-b1_r) : 24'(b1_r);
  assign b2_mag  = b2_r[23] ? 24'(-b2_r) : 24'(b2_r);
  assign dn1_mag = dn1[24] ? 25'(-dn1) : 25'(dn1);
  assign dn2_mag = dn2[24] ? 25'(-dn2) : 25'(dn2);

  always_comb begin
    if (!cmd.div_phase) begin
      da_num = num1_r;        da_den = den_r;          da_neg = neg1_r;
      db_num = num2_r;        db_den = den_r;          db_neg = neg2_r;
    end else begin
      da_num = 64'(b1_mag);   da_den = 64'(dn1_mag);   da_neg = b1_r[23] ^ dn1[24];
      db_num = 64'(b2_mag);   db_den = 64'(dn2_mag);   db_neg = b2_r[23] ^ dn2[24];
    end
  end

  qfe_div u_div_a (
    .clk, .rst_n, .start(cmd.div_start), .neg(da_neg), .num(da_num), .den(da_den),
    .busy(busy_a), .quo(quo_a)
  );

  qfe_div u_div_b (
    .clk, .rst_n, .start(cmd.div_start), .neg(db_neg), .num(db_num), .den(db_den),
    .busy(busy_b), .quo(quo_b)
  );

  // Quotient latch; delta2 wins only when both deltas are positive
  always_ff @(posedge clk) begin
    if (cmd.div_latch) begin
      if (!cmd.div_phase) begin
        b1_r <= quo_a;
        b2_r <= quo_b;
      end else begin
        d_r <= (quo_a > 24'sd0 && quo_b > 24'sd0) ? quo_b : quo_a;
      end
    end
  end

  // Held result and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      out_stat_r  <= STAT_OK;
      hpk_r       <= '0;
      hcoarse_r   <= '0;
      hoff_r      <= '0;
      hfreq_r     <= '0;
      hconf_r     <= '0;
      hvalid_r    <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
      out_stat_r  <= stat_r;
      if (stat_r == STAT_OK) begin
        hpk_r     <= k_r;
        hcoarse_r <= coarse_r;
        hoff_r    <= d_r;
        hfreq_r   <= fine_r;
        hconf_r   <= conf_r;
        hvalid_r  <= (conf_r >= confidence_threshold);
      end else if (stat_r == STAT_ZERO_PEAK) begin
        hpk_r     <= k_r;
        hcoarse_r <= coarse_r;
        hconf_r   <= '0;
        hvalid_r  <= 1'b0;
      end
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign sts.reject   = (stat_r != STAT_OK);
  assign sts.den_zero = (den_r == 64'd0);
  assign sts.div_busy = busy_a | busy_b;
  assign sts.out_free = !out_valid_r || !out_stall;

  assign out_valid          = out_valid_r;
  assign out_status         = out_stat_r;
  assign out_bin_index      = hpk_r;
  assign out_coarse_freq    = hcoarse_r;
  assign out_fine_offset    = hoff_r;
  assign out_fine_frequency = hfreq_r;
  assign out_confidence     = hconf_r;
  assign out_valid_res      = hvalid_r;

endmodule

// ===== rtl/qfe_ctrl.sv =====
// Controller: sequences capture, products, divisions and result commit.
module qfe_ctrl import qfe_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  qfe_sts_t sts,
  output qfe_cmd_t cmd
);

  qfe_state_t state_r, state_nxt;
  logic [2:0] step_r, step_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    unique case (state_r)
      ST_IDLE:  if (in_valid) state_nxt = ST_CHECK;
      ST_CHECK: begin
        step_nxt  = '0;
        state_nxt = sts.reject ? ST_DONE : ST_MULA;
      end
      ST_MULA: begin
        if (step_r == MULA_LAST) state_nxt = ST_ZCHK;
        else                     step_nxt  = step_r + 3'd1;
      end
      ST_ZCHK:  state_nxt = sts.den_zero ? ST_DONE : ST_DIV1W;
      ST_DIV1W: if (!sts.div_busy) state_nxt = ST_DIV2S;
      ST_DIV1S: state_nxt = ST_DIV1W;
      ST_DIV2S: state_nxt = ST_DIV2W;
      ST_DIV2W: begin
        if (!sts.div_busy) begin
          state_nxt = ST_MULB;
          step_nxt  = '0;
        end
      end
      ST_MULB: begin
        if (step_r == MULB_LAST) state_nxt = ST_DONE;
        else                     step_nxt  = step_r + 3'd1;
      end
      ST_DONE:  if (sts.out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd = '{load: 1'b0, zchk: 1'b0, mop: MOP_KFS, con: CON_NONE, div_start: 1'b0,
            div_phase: 1'b0, div_latch: 1'b0, commit: 1'b0};
    in_stall = (state_r != ST_IDLE);
    unique case (state_r)
      ST_IDLE:  cmd.load = in_valid;
      ST_MULA: begin
        cmd.mop = mula_op(step_r);
        cmd.con = mula_con(step_r);
      end
      ST_ZCHK: begin
        cmd.zchk      = 1'b1;
        cmd.div_start = !sts.den_zero;
      end
      ST_DIV1W: cmd.div_latch = !sts.div_busy;
      ST_DIV2S: begin
        cmd.div_phase = 1'b1;
        cmd.div_start = 1'b1;
      end
      ST_DIV2W: begin
        cmd.div_phase = 1'b1;
        cmd.div_latch = !sts.div_busy;
      end
      ST_MULB: begin
        cmd.mop = mulb_op(step_r);
        cmd.con = mulb_con(step_r);
      end
      ST_DONE:  cmd.commit = sts.out_free;
      default: ;
    endcase
  end

endmodule

// ===== rtl/quinn_frequency_estimator_unit.sv =====
// Quinn first-estimator frequency interpolation unit: config registers and top level.
// A normal peak is handled in order: capture and products, two 23-step divider passes (beta
// pair, then delta pair), the final fine-frequency and confidence products and the commit.
// Rejects (disabled, bad index) skip to the commit after capture, a zero peak after the first products.
// Transactions: one at a time, the next taken the cycle after the commit.
// Reset (rst_n, synchronous): registers to enable=1, 1 MHz, threshold 0.5; held result zero.
module quinn_frequency_estimator_unit import qfe_pkg::*; #(
  parameter int FFT_POINTS = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  // Configuration port
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [3:0]         cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready,
  // Input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [9:0]         in_bin_index,
  input  logic signed [31:0] in_re_prev,
  input  logic signed [31:0] in_im_prev,
  input  logic signed [31:0] in_re_peak,
  input  logic signed [31:0] in_im_peak,
  input  logic signed [31:0] in_re_next,
  input  logic signed [31:0] in_im_next,
  // Result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_status,
  output logic [9:0]         out_bin_index,
  output logic [30:0]        out_coarse_freq,
  output logic signed [23:0] out_fine_offset,
  output logic signed [47:0] out_fine_frequency,
  output logic [16:0]        out_confidence,
  output logic               out_valid_res
);

  logic        enable_r;
  logic [23:0] fs_r;
  logic [16:0] thr_r;
  logic        cfg_wr;
  qfe_cmd_t    cmd;
  qfe_sts_t    sts;

  // Configuration registers
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b1;
      fs_r     <= 24'd1000000;
      thr_r    <= 17'd32768;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[3:2])
        REG_ENABLE:    enable_r <= cfg_pwdata[0];
        REG_SAMPLE_HZ: fs_r     <= cfg_pwdata[23:0];
        REG_THRESHOLD: thr_r    <= cfg_pwdata[16:0];
        default: ;
      endcase
    end
  end

  // Register read
  always_comb begin
    unique case (cfg_paddr[3:2])
      REG_ENABLE:    cfg_prdata = 32'(enable_r);
      REG_SAMPLE_HZ: cfg_prdata = 32'(fs_r);
      REG_THRESHOLD: cfg_prdata = 32'(thr_r);
      default:       cfg_prdata = '0;
    endcase
  end

  qfe_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .sts, .cmd
  );

  qfe_datapath #(.FFT_POINTS(FFT_POINTS)) u_dp (
    .clk, .rst_n, .cmd, .sts,
    .enable(enable_r), .sample_rate_hz(fs_r), .confidence_threshold(thr_r),
    .in_bin_index, .in_re_prev, .in_im_prev, .in_re_peak, .in_im_peak,
    .in_re_next, .in_im_next,
    .out_stall, .out_valid, .out_status, .out_bin_index, .out_coarse_freq,
    .out_fine_offset, .out_fine_frequency, .out_confidence, .out_valid_res
  );

endmodule

// ===== bench/tb.sv =====
// Testbench for the Quinn frequency estimator: directed table, then random checked traffic.
`timescale 1ns / 100ps

module tb;
  import qfe_pkg::*;

  localparam int NPTS = 1024;
  localparam int N_RANDOM = 830;
  localparam longint CYCLE_LIMIT = 400000;

  // One estimate as it appears on the result port
  typedef struct packed {
    logic [1:0]         status;
    logic [9:0]         bin_index;
    logic [30:0]        coarse;
    logic signed [23:0] offset;
    logic signed [47:0] freq;
    logic [16:0]        conf;
    logic               vres;
  } estimate_t;

  // One peak request
  typedef struct packed {
    logic [9:0]         k;
    logic signed [31:0] rp, ip, rk, ik, rn, in_;
  } peak_req_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [3:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [9:0] in_bin_index = '0;
  logic signed [31:0] in_re_prev = '0, in_im_prev = '0, in_re_peak = '0;
  logic signed [31:0] in_im_peak = '0, in_re_next = '0, in_im_next = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] out_status;
  logic [9:0] out_bin_index;
  logic [30:0] out_coarse_freq;
  logic signed [23:0] out_fine_offset;
  logic signed [47:0] out_fine_frequency;
  logic [16:0] out_confidence;
  logic out_valid_res;

  quinn_frequency_estimator_unit #(.FFT_POINTS(NPTS)) u_top (.*);

  always #4 clk = ~clk;

  // Predictor state and register copies
  logic        en_q;
  logic [23:0] fs_q;
  logic [16:0] thr_q;
  estimate_t   held_q;
  estimate_t   pending_estimates[$];
  int          fail_count = 0;
  longint      cycle_count = 0;
  int          send_idle_pct = 0, stall_pct = 0;
  bit          hold_off = 1'b0;

  // Signed Q8.16 quotient of magnitudes, truncated and saturated
  function automatic longint q16_ratio(bit neg, logic [63:0] num, logic [63:0] den);
    logic [63:0] q, r, frac;
    q = num / den;
    r = num % den;
    if (q >= 128) return neg ? -64'sd8388608 : 64'sd8388607;
    frac = 0;
    for (int i = 0; i < 16; i++) begin
      r = r << 1;
      frac = frac << 1;
      if (r >= den) begin
        r -= den;
        frac |= 1;
      end
    end
    q = (q << 16) | frac;
    return neg ? -longint'(q) : longint'(q);
  endfunction

  function automatic logic [63:0] mag(longint v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  // Real part of x / peak: the cross products divided by the peak's squared magnitude
  function automatic longint beta_of(longint xr, longint xi, longint pr, longint pi,
                                     logic [63:0] den);
    longint p1, p2;
    bit n1, n2, neg;
    logic [63:0] m1, m2, m;
    p1 = xr * pr;
    p2 = xi * pi;
    n1 = p1 < 0;
    n2 = p2 < 0;
    m1 = mag(p1);
    m2 = mag(p2);
    if (n1 == n2) begin
      neg = n1;
      m = m1 + m2;
    end else if (m1 >= m2) begin
      neg = n1;
      m = m1 - m2;
    end else begin
      neg = n2;
      m = m2 - m1;
    end
    if (m == 0) return 0;
    return q16_ratio(neg, m, den);
  endfunction

  function automatic longint delta_div(longint num, longint den);
    if (den == 0 || num == 0) return 0;
    return q16_ratio((num < 0) != (den < 0), mag(num), mag(den));
  endfunction

  function automatic logic [16:0] conf_of(longint d);
    logic [63:0] a;
    a = mag(d);
    if (100 * a <= 65536) return 17'd65536;
    if (10 * a <= 65536) return 17'((6422528 - 800 * a) / 100);
    if (2 * a <= 65536) return 17'((1572864 - 40 * a) / 100);
    return 17'd0;
  endfunction

  // Update held estimate for one request and return what the port shows
  function automatic estimate_t estimate_peak(peak_req_t r);
    estimate_t e;
    logic [1:0] st;
    logic [63:0] den, fm;
    longint b1, b2, d1, d2, d, pos;
    if (!en_q) st = STAT_DISABLED;
    else if (r.k == 0 || r.k >= NPTS / 2 - 1) st = STAT_BAD_INDEX;
    else begin
      den = mag(r.rk) * mag(r.rk) + mag(r.ik) * mag(r.ik);
      held_q.bin_index = r.k;
      held_q.coarse = 31'((64'(r.k) * fs_q * 256) / NPTS);
      if (den == 0) begin
        held_q.conf = 0;
        held_q.vres = 0;
        st = STAT_ZERO_PEAK;
      end else begin
        b1 = beta_of(r.rp, r.ip, r.rk, r.ik, den);
        b2 = beta_of(r.rn, r.in_, r.rk, r.ik, den);
        d1 = delta_div(b1, 65536 - b1);
        d2 = delta_div(b2, b2 - 65536);
        d = (d1 > 0 && d2 > 0) ? d2 : d1;
        pos = (longint'(r.k) << 16) + d;
        fm = (mag(pos) * fs_q) / (256 * NPTS);
        held_q.offset = 24'(d);
        held_q.freq = pos < 0 ? -48'(fm) : 48'(fm);
        held_q.conf = conf_of(d);
        held_q.vres = held_q.conf >= thr_q;
        st = STAT_OK;
      end
    end
    e = held_q;
    e.status = st;
    return e;
  endfunction

  // Register write over the APB port, only while idle
  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= val;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    case (idx)
      REG_ENABLE:    en_q = val[0];
      REG_SAMPLE_HZ: fs_q = val[23:0];
      default:       thr_q = val[16:0];
    endcase
  endtask

  // Stop offering and wait for every expected result
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_estimates.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  // Offer one transaction and wait until it is taken; valid drops while idling or in drain
  task automatic send_peak(peak_req_t r);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    {in_bin_index, in_re_prev, in_im_prev, in_re_peak, in_im_peak, in_re_next,
     in_im_next} <= r;
    do @(posedge clk); while (in_stall);
    pending_estimates.push_back(estimate_peak(r));
    @(negedge clk);
  endtask

  // Directed check with a typed expectation
  task automatic send_expect(peak_req_t r, estimate_t e);
    estimate_t p;
    send_peak(r);
    p = pending_estimates[$];
    if (p !== e) begin
      $error("directed row: predictor %h, table %h", p, e);
      fail_count++;
    end
  endtask

  function automatic peak_req_t rand_req();
    peak_req_t r;
    int sh;
    r.k = 10'($urandom);
    r.rp = $urandom;
    r.ip = $urandom;
    r.rk = $urandom;
    r.ik = $urandom;
    r.rn = $urandom;
    r.in_ = $urandom;
    // Mostly well-formed peaks: valid index, real parts of the neighbors smaller than the peak's
    if ($urandom_range(9) < 8) begin
      r.k = 10'($urandom_range(510, 1));
      sh = $urandom_range(31, 0);
      r.rk = $signed($urandom) >>> (31 - sh);
      r.ik = $signed($urandom) >>> (31 - $urandom_range(31, 0));
      r.rp = $signed($urandom) >>> (32 - sh > 31 ? 31 : 32 - sh + $urandom_range(2));
      r.ip = $signed($urandom) >>> $urandom_range(31, 0);
      r.rn = $signed($urandom) >>> (32 - sh > 31 ? 31 : 32 - sh + $urandom_range(2));
      r.in_ = $signed($urandom) >>> $urandom_range(31, 0);
      if ($urandom_range(19) == 0) {r.rk, r.ik} = '0;
    end
    return r;
  endfunction

  // Result checker
  always @(posedge clk) begin
    estimate_t got, want;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_status, out_bin_index, out_coarse_freq, out_fine_offset,
             out_fine_frequency, out_confidence, out_valid_res};
      if (pending_estimates.size() == 0) begin
        $error("result transaction with nothing expected: %h", got);
        fail_count++;
      end else begin
        want = pending_estimates.pop_front();
        if (got.status !== want.status) begin
          $error("status exp %0d got %0d", want.status, got.status); fail_count++;
        end
        if (got.bin_index !== want.bin_index) begin
          $error("bin_index exp %0d got %0d", want.bin_index, got.bin_index);
          fail_count++;
        end
        if (got.coarse !== want.coarse) begin
          $error("coarse_freq exp %0d got %0d", want.coarse, got.coarse);
          fail_count++;
        end
        if (got.offset !== want.offset) begin
          $error("fine_offset exp %0d got %0d", want.offset, got.offset); fail_count++;
        end
        if (got.freq !== want.freq) begin
          $error("fine_frequency exp %0d got %0d", want.freq, got.freq); fail_count++;
        end
        if (got.conf !== want.conf) begin
          $error("confidence exp %0d got %0d", want.conf, got.conf); fail_count++;
        end
        if (got.vres !== want.vres) begin
          $error("valid_res exp %0d got %0d", want.vres, got.vres); fail_count++;
        end
      end
    end
  end

  // Receiver stall driver
  always @(negedge clk) begin
    out_stall <= hold_off || (stall_pct != 0 && $urandom_range(99) < stall_pct);
  end

  // Timeout
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Long hold-off on the result side during the pressure phase
  task automatic long_hold();
    hold_off = 1'b1;
    repeat (600) @(negedge clk);
    hold_off = 1'b0;
  endtask

  initial begin
    peak_req_t r;
    estimate_t zero_e;
    en_q = 1'b1;
    fs_q = 24'd1000000;
    thr_q = 17'd32768;
    held_q = '0;
    zero_e = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: rejects right after reset show the zero held result
    zero_e.status = STAT_BAD_INDEX;
    send_expect({10'd0, {6{32'sd5}}}, zero_e);
    send_expect({10'd511, {6{32'sd5}}}, zero_e);
    send_expect({10'd1023, {6{-32'sd1}}}, zero_e);
    zero_e.status = STAT_ZERO_PEAK;
    zero_e.bin_index = 10'd1;
    zero_e.coarse = 31'd250000;
    send_expect({10'd1, 32'sd7, 32'sd7, 32'sd0, 32'sd0, 32'sd7, 32'sd7}, zero_e);
    // Pure peak: zero neighbors give delta 0 and full confidence
    send_peak({10'd100, 32'sd0, 32'sd0, 32'sd1000, 32'sd0, 32'sd0, 32'sd0});
    send_peak({10'd510, 32'sd0, 32'sd0, -32'sd1, 32'sd0, 32'sd0, 32'sd0});
    // Extremes of the fields
    send_peak({10'd510, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
               32'h7FFFFFFF, 32'h7FFFFFFF});
    send_peak({10'd1, 32'h7FFFFFFF, 32'h80000000, 32'sd1, 32'sd0, 32'h80000000, 32'sd1});
    send_peak({10'd2, 32'sd100, 32'sd0, 32'sd100, 32'sd0, 32'sd0, 32'sd0});
    send_peak({10'd300, 32'sd0, 32'sd0, 32'sd100, 32'sd0, 32'sd100, 32'sd0});
    send_peak({10'd50, 32'sd30, 32'sd5, 32'sd100, 32'sd20, 32'sd40, -32'sd3});
    send_peak({10'd50, -32'sd30, 32'sd5, 32'sd100, -32'sd20, 32'sd8, 32'sd3});
    send_peak({10'd50, 32'sd0, 32'sd0, 32'sd100, 32'sd0, -32'sd5, 32'sd0});
    drain();

    // Disabled, minimum and maximum rate, threshold extremes
    write_reg(REG_ENABLE, 32'd0);
    send_peak({10'd77, 32'sd1, 32'sd2, 32'sd3, 32'sd4, 32'sd5, 32'sd6});
    drain();
    write_reg(REG_ENABLE, 32'd1);
    write_reg(REG_SAMPLE_HZ, 32'd1);
    write_reg(REG_THRESHOLD, 32'd0);
    send_peak({10'd80, 32'sd10, 32'sd0, 32'sd100, 32'sd0, 32'sd30, 32'sd0});
    drain();
    write_reg(REG_SAMPLE_HZ, 32'hFFFFFFFF);
    write_reg(REG_THRESHOLD, 32'd65536);
    send_peak({10'd510, 32'sd10, 32'sd0, 32'sd100, 32'sd0, 32'sd30, 32'sd0});
    send_peak({10'd3, 32'sd0, 32'sd0, 32'sd100, 32'sd0, 32'sd0, 32'sd0});
    drain();
    write_reg(REG_SAMPLE_HZ, 32'd0);
    send_peak({10'd9, 32'sd10, 32'sd0, 32'sd100, 32'sd0, 32'sd30, 32'sd0});
    drain();

    // Random phases over several register settings
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 84; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 84; end
        3: begin send_idle_pct = 21; stall_pct = 21; end
        default: begin send_idle_pct = 0; stall_pct = 0; end
      endcase
      write_reg(REG_ENABLE, (ph == 3) ? 32'($urandom_range(9) != 0) : 32'd1);
      write_reg(REG_SAMPLE_HZ, $urandom_range(16777215, 1));
      write_reg(REG_THRESHOLD, $urandom_range(65536));
      fork
        if (ph == 4) long_hold();
        for (int i = 0; i < N_RANDOM / 5; i++) begin
          r = rand_req();
          send_peak(r);
        end
      join
      drain();
    end

    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
